>>> sv/assert_macros.svh
// Assertion macros shared by the mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define GLAM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition forces an outcome on the next edge.
`define GLAM_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> sv/glam_pkg.sv
// Shared constants and types for the gamut limit axis mapper.
package glam_pkg;

    localparam int SEG_COUNT   = 256;
    localparam int MODEL_COUNT = 5;
    localparam int AXIS_COUNT  = 3;
    localparam int ROW_WORDS   = 4;
    localparam int ROW_DEPTH   = MODEL_COUNT * AXIS_COUNT * (SEG_COUNT + 1);
    localparam int TABLE_DEPTH = ROW_DEPTH * ROW_WORDS;
    localparam int ROW_AW      = $clog2(ROW_DEPTH);
    localparam int POS_PROD_W  = 17 + $clog2(SEG_COUNT);
    localparam int ONE_Q16     = 65536;
    localparam int DIV_STEPS   = 31;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_MAP   = 2'd1,
        OP_UNMAP = 2'd2
    } t_op;

    // Per-coordinate unmap decode plus the finished map result.
    typedef struct packed {
        logic             unmap;
        logic [1:0][31:0] mres;
        logic [1:0]       neg;
        logic [1:0]       zero;
        logic [1:0]       nneg;
        logic [1:0]       nzero;
        logic [1:0]       ovf;
    } t_side;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        status;
    } t_word;

endpackage

>>> sv/glam_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module glam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

>>> sv/glam_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module glam_div import glam_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_adv,
    input  logic [31:0]          i_rem,
    input  logic [DIV_STEPS-1:0] i_low,
    input  logic [31:0]          i_divisor,
    output logic [DIV_STEPS-1:0] o_quot
);

    logic [31:0]          r_rem  [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_low  [DIV_STEPS];
    logic [31:0]          r_dvs  [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quot [DIV_STEPS];

    logic [31:0]          s_rem  [DIV_STEPS];
    logic [DIV_STEPS-1:0] s_low  [DIV_STEPS];
    logic [31:0]          s_dvs  [DIV_STEPS];
    logic [DIV_STEPS-1:0] s_quot [DIV_STEPS];
    logic [32:0]          trial  [DIV_STEPS];
    logic                 ge     [DIV_STEPS];

    logic [31:0]          n_rem  [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_low  [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_quot [DIV_STEPS];

    always_comb begin
        for (int s = 0; s < DIV_STEPS; s++) begin
            if (s == 0) begin
                s_rem[s]  = i_rem;
                s_low[s]  = i_low;
                s_dvs[s]  = i_divisor;
                s_quot[s] = '0;
            end else begin
                s_rem[s]  = r_rem[s-1];
                s_low[s]  = r_low[s-1];
                s_dvs[s]  = r_dvs[s-1];
                s_quot[s] = r_quot[s-1];
            end
            // shift in the next dividend bit, subtract when it fits
            trial[s]  = {s_rem[s], s_low[s][DIV_STEPS-1]};
            ge[s]     = trial[s] >= {1'b0, s_dvs[s]};
            n_rem[s]  = ge[s] ? 32'(trial[s] - {1'b0, s_dvs[s]}) : trial[s][31:0];
            n_low[s]  = {s_low[s][DIV_STEPS-2:0], 1'b0};
            n_quot[s] = {s_quot[s][DIV_STEPS-2:0], ge[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_rem[s]  <= n_rem[s];
                r_low[s]  <= n_low[s];
                r_dvs[s]  <= s_dvs[s];
                r_quot[s] <= n_quot[s];
            end
        end
    end

    assign o_quot = r_quot[DIV_STEPS-1];

endmodule

>>> sv/gamut_limit_axis_mapper.sv
// Top level of the gamut limit axis mapper: table, interpolation and map/unmap pipeline.
//
// Input channel (i_valid / o_stall) carries one word per accepted edge. A load word
// (op 0) writes one table word at once and gives no result; a map (op 1) or unmap
// (op 2) word gives one result word; op 3 is dropped.
// Output channel (o_valid / i_stall) carries out_x, out_y and status.
// Path: the table read of a map or unmap word is issued at the accepting edge, then
// come six interpolation, span and product/rounding stages, 31 stages of the restoring
// divider (one quotient bit each) and one output register. Map words take the same path
// so results leave in order.
// Throughput: one word per cycle while o_stall is low; every stage advances together.
// When the receiver stalls, the output register holds its word and one more word
// lands in a skid register; only then does o_stall rise and the pipeline freeze,
// so nothing is lost or repeated. o_stall is a register and never depends on i_valid.
// Reset clears every valid bit but not the output and skid word data. The limit table
// is not cleared: load every row before mapping with it.
// Table: four banks (one per row word), each read at the lower and upper row of
// the bracketing segment in the same cycle.
module gamut_limit_axis_mapper import glam_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic [2:0]         i_model,
    input  logic [1:0]         i_axis_pick,
    input  logic [16:0]        i_position,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic [13:0]        i_load_index,
    input  logic signed [31:0] i_load_word,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_status
);

`include "assert_macros.svh"

    function automatic logic [31:0] sat_q16(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // advance the whole pipeline unless the skid register is occupied
    logic r_skid_valid;
    logic adv;
    logic acc;
    logic item;
    assign adv     = !r_skid_valid;
    assign o_stall = !adv;
    assign acc     = i_valid && adv;
    assign item    = acc && (i_op == OP_MAP || i_op == OP_UNMAP);

    // ---------------- table addressing ----------------
    logic [16:0]           pos_sat;
    logic [POS_PROD_W-1:0] pos_prod;
    logic [15:0]           frac;
    logic [ROW_AW-1:0]     addr_lo;
    logic [ROW_AW-1:0]     addr_hi;
    logic                  unknown;
    logic [ROW_AW-1:0]     ram_waddr;
    logic [ROW_WORDS-1:0]  ram_we;
    logic                  load_ok;

    always_comb begin
        pos_sat  = (i_position > 17'(ONE_Q16)) ? 17'(ONE_Q16) : i_position;
        pos_prod = POS_PROD_W'(pos_sat) * POS_PROD_W'(SEG_COUNT);
        frac     = pos_prod[15:0];
        addr_lo  = ROW_AW'((32'(i_model) * AXIS_COUNT + 32'(i_axis_pick)) * (SEG_COUNT + 1)
                   + 32'(pos_prod >> 16));
        addr_hi  = addr_lo + ROW_AW'(frac != 16'd0);
        unknown  = (32'(i_model) >= MODEL_COUNT) || (32'(i_axis_pick) >= AXIS_COUNT);
        load_ok  = acc && (i_op == OP_LOAD) && (32'(i_load_index) < TABLE_DEPTH);
        ram_waddr = ROW_AW'(i_load_index >> 2);
        for (int k = 0; k < ROW_WORDS; k++) begin
            ram_we[k] = load_ok && (i_load_index[1:0] == 2'(k));
        end
    end

    logic [31:0] rd_lo [ROW_WORDS];
    logic [31:0] rd_hi [ROW_WORDS];

    for (genvar k = 0; k < ROW_WORDS; k++) begin : g_bank
        glam_ram #(
            .WIDTH (32),
            .DEPTH (ROW_DEPTH)
        ) u_bank (
            .i_clk     (i_clk),
            .i_we      (ram_we[k]),
            .i_waddr   (ram_waddr),
            .i_wdata   (i_load_word),
            .i_re      (adv),
            .i_raddr_a (addr_lo),
            .i_raddr_b (addr_hi),
            .o_rdata_a (rd_lo[k]),
            .o_rdata_b (rd_hi[k])
        );
    end

    // ---------------- stage registers ----------------
    logic                 r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    logic                 r1_unmap, r2_unmap, r3_unmap, r4_unmap, r5_unmap, r6_unmap, r7_unmap;
    logic                 r1_unk, r2_unk;
    logic [15:0]          r1_f;
    logic signed [31:0]   r1_c [2];
    logic signed [31:0]   r2_c [2];
    logic signed [31:0]   r3_c [2];
    logic signed [31:0]   r4_c [2];
    logic signed [49:0]   r2_pa [ROW_WORDS];
    logic signed [49:0]   r2_pb [ROW_WORDS];
    logic signed [31:0]   r3_lim [ROW_WORDS];
    logic signed [31:0]   r4_min [2];
    logic signed [32:0]   r4_span [2];
    logic signed [32:0]   r4_num [2];
    logic signed [31:0]   r5_min [2];
    logic signed [64:0]   r5_prod [2];
    logic signed [31:0]   r6_min [2];
    logic signed [48:0]   r6_m [2];
    logic [31:0]          r7_mres [2];
    logic [47:0]          r5_an [2];
    logic [47:0]          r6_an [2];
    logic [47:0]          r7_an [2];
    logic [31:0]          r5_as [2];
    logic [31:0]          r6_as [2];
    logic [31:0]          r7_as [2];
    logic [1:0]           r5_neg, r6_neg, r7_neg;
    logic [1:0]           r5_zero, r6_zero, r7_zero;
    logic [1:0]           r5_nneg, r6_nneg, r7_nneg;
    logic [1:0]           r5_nzero, r6_nzero, r7_nzero;
    logic [1:0]           r6_ovf, r7_ovf;
    logic [DIV_STEPS-1:0] r_div_v;
    t_side                r_side [DIV_STEPS];

    // ---------------- stage arithmetic ----------------
    logic [16:0]        w_inv;
    logic signed [49:0] n_pa [ROW_WORDS];
    logic signed [49:0] n_pb [ROW_WORDS];
    logic signed [49:0] lim_sum [ROW_WORDS];
    logic signed [31:0] n_lim [ROW_WORDS];
    logic signed [32:0] n_span [2];
    logic signed [32:0] n_num [2];
    logic signed [64:0] n_prod [2];
    logic [32:0]        abs_num [2];
    logic [32:0]        abs_span [2];
    logic signed [64:0] prod_rnd [2];
    logic signed [49:0] mres_sum [2];
    t_side              n_side;

    always_comb begin
        // lower row weight is one minus the fraction
        w_inv = 17'(ONE_Q16) - {1'b0, r1_f};
        for (int k = 0; k < ROW_WORDS; k++) begin
            n_pa[k] = $signed({{18{rd_lo[k][31]}}, rd_lo[k]}) * $signed({33'd0, w_inv});
            n_pb[k] = $signed({{18{rd_hi[k][31]}}, rd_hi[k]}) * $signed({34'd0, r1_f});
            lim_sum[k] = r2_pa[k] + r2_pb[k] + 50'sd32768;
            if (r2_unk) begin
                n_lim[k] = (k >= 2) ? 32'sd65536 : 32'sd0;
            end else begin
                n_lim[k] = lim_sum[k][47:16];
            end
        end
        for (int j = 0; j < 2; j++) begin
            n_span[j] = {r3_lim[j+2][31], r3_lim[j+2]} - {r3_lim[j][31], r3_lim[j]};
            n_num[j]  = {r3_c[j][31], r3_c[j]} - {r3_lim[j][31], r3_lim[j]};
            n_prod[j] = $signed({{33{r4_c[j][31]}}, r4_c[j]})
                      * $signed({{32{r4_span[j][32]}}, r4_span[j]});
            abs_num[j]  = r4_num[j][32] ? 33'(-r4_num[j]) : r4_num[j];
            abs_span[j] = r4_span[j][32] ? 33'(-r4_span[j]) : r4_span[j];
            prod_rnd[j] = r5_prod[j] + 65'sd32768;
            mres_sum[j] = {r6_m[j][48], r6_m[j]} + {{18{r6_min[j][31]}}, r6_min[j]};
        end
        n_side.unmap = r7_unmap;
        for (int j = 0; j < 2; j++) begin
            n_side.mres[j]  = r7_mres[j];
            n_side.neg[j]   = r7_neg[j];
            n_side.zero[j]  = r7_zero[j];
            n_side.nneg[j]  = r7_nneg[j];
            n_side.nzero[j] = r7_nzero[j];
            n_side.ovf[j]   = r7_ovf[j];
        end
    end

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r_div_v <= '0;
        end else if (adv) begin
            r1_v    <= item;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r7_v    <= r6_v;
            r_div_v <= {r_div_v[DIV_STEPS-2:0], r7_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // table read issued this cycle; capture the item beside it
            r1_unmap <= (i_op == OP_UNMAP);
            r1_unk   <= unknown;
            r1_f     <= frac;
            r1_c[0]  <= i_coord_x;
            r1_c[1]  <= i_coord_y;
            // weighted row words
            r2_unmap <= r1_unmap;
            r2_unk   <= r1_unk;
            r2_c     <= r1_c;
            r2_pa    <= n_pa;
            r2_pb    <= n_pb;
            // interpolated limits
            r3_unmap <= r2_unmap;
            r3_c     <= r2_c;
            r3_lim   <= n_lim;
            // span and offset from minimum
            r4_unmap <= r3_unmap;
            r4_c     <= r3_c;
            r4_span  <= n_span;
            r4_num   <= n_num;
            r4_min[0] <= r3_lim[0];
            r4_min[1] <= r3_lim[1];
            // map product, unmap magnitudes
            r5_unmap <= r4_unmap;
            r5_min   <= r4_min;
            r5_prod  <= n_prod;
            for (int j = 0; j < 2; j++) begin
                r5_an[j]    <= {abs_num[j][31:0], 16'd0};
                r5_as[j]    <= abs_span[j][31:0];
                r5_neg[j]   <= r4_num[j][32] ^ r4_span[j][32];
                r5_zero[j]  <= (r4_span[j] == 33'sd0);
                r5_nneg[j]  <= r4_num[j][32];
                r5_nzero[j] <= (r4_num[j] == 33'sd0);
            end
            // rounding shift, quotient range check
            r6_unmap <= r5_unmap;
            r6_min   <= r5_min;
            r6_an    <= r5_an;
            r6_as    <= r5_as;
            r6_neg   <= r5_neg;
            r6_zero  <= r5_zero;
            r6_nneg  <= r5_nneg;
            r6_nzero <= r5_nzero;
            for (int j = 0; j < 2; j++) begin
                r6_m[j]   <= prod_rnd[j][64:16];
                r6_ovf[j] <= {15'd0, r5_an[j][47:31]} >= r5_as[j];
            end
            // map result finished; unmap enters the divider
            r7_unmap <= r6_unmap;
            r7_an    <= r6_an;
            r7_as    <= r6_as;
            r7_neg   <= r6_neg;
            r7_zero  <= r6_zero;
            r7_nneg  <= r6_nneg;
            r7_nzero <= r6_nzero;
            r7_ovf   <= r6_ovf;
            for (int j = 0; j < 2; j++) begin
                r7_mres[j] <= sat_q16(mres_sum[j]);
            end
            r_side[0] <= n_side;
            for (int s = 1; s < DIV_STEPS; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // ---------------- dividers ----------------
    logic [DIV_STEPS-1:0] quot [2];

    for (genvar j = 0; j < 2; j++) begin : g_div
        glam_div u_div (
            .i_clk     (i_clk),
            .i_adv     (adv),
            .i_rem     ({15'd0, r7_an[j][47:31]}),
            .i_low     (r7_an[j][DIV_STEPS-1:0]),
            .i_divisor (r7_as[j]),
            .o_quot    (quot[j])
        );
    end

    // ---------------- result select ----------------
    t_side       last;
    logic [31:0] ures [2];
    t_word       fin;

    always_comb begin
        last = r_side[DIV_STEPS-1];
        for (int j = 0; j < 2; j++) begin
            if (last.zero[j]) begin
                if (last.nzero[j]) begin
                    ures[j] = 32'd0;
                end else begin
                    ures[j] = last.nneg[j] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
            end else if (last.ovf[j]) begin
                ures[j] = last.neg[j] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                ures[j] = last.neg[j] ? 32'(-{1'b0, quot[j]}) : {1'b0, quot[j]};
            end
        end
        fin.x      = last.unmap ? ures[0] : last.mres[0];
        fin.y      = last.unmap ? ures[1] : last.mres[1];
        fin.status = last.unmap && (last.zero != 2'b00);
    end

    // ---------------- output register and skid ----------------
    logic  r_out_valid;
    t_word r_out;
    t_word r_skid;
    logic  arrive;
    logic  take;

    assign arrive = adv && r_div_v[DIV_STEPS-1];
    assign take   = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // drain the skid word into the output register
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (arrive) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (arrive) begin
            if (!r_out_valid || take) begin
                r_out <= fin;
            end else begin
                r_skid <= fin;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_out_x  = r_out.x;
    assign o_out_y  = r_out.y;
    assign o_status = r_out.status;

    `GLAM_ASSERT(a_skid_has_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid word without output word")
    `GLAM_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, r_out_valid && i_stall, r_out_valid, "stalled output word dropped")
    `GLAM_ASSERT_NEXT(a_load_no_word, i_clk, i_rst_n, i_valid && !o_stall && i_op == OP_LOAD, !r1_v, "load word entered pipeline")

endmodule
